### sv/tsp_pkg.sv
`default_nettype none
package tsp_pkg;

	localparam int BANKS       = 8;
	localparam int BANK_DEPTH  = 16384;
	localparam int FRAC_BITS   = 12;
	localparam int SAMPLE_BITS = 16;
	localparam int STORE_DEPTH = BANKS * BANK_DEPTH;
	localparam int DIV_STEPS   = 20;

	localparam logic signed [15:0] TUNE_MIN = 16'sd819;
	localparam logic signed [15:0] TUNE_MAX = 16'sd7373;

	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_SAMPLE = 2'd1;
	localparam logic [1:0] REQ_LEN    = 2'd2;

	localparam logic [1:0] CFG_BANK_COUNT = 2'd0;
	localparam logic [1:0] CFG_STEP_SPAN  = 2'd1;
	localparam logic [1:0] CFG_GATE_THR   = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE, S_EVAL, S_READ, S_DRAIN, S_ROUND, S_DIV, S_SAT, S_DONE
	} state_t;

	typedef enum logic [1:0] {
		MODE_ZERO, MODE_DIRECT, MODE_MIX
	} mode_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic read;
		logic drain;
		logic round;
		logic div;
		logic sat;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic  is_tick;
		mode_t mode;
		logic  direct;
		logic  last_read;
		logic  out_busy;
	} status_t;

endpackage
`default_nettype wire

### sv/tsp_ram.sv
`default_nettype none
module tsp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 131072
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### sv/tsp_ctrl.sv
`default_nettype none
module tsp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire tsp_pkg::status_t  st,
	output tsp_pkg::cmd_t          cmd
);
	import tsp_pkg::*;

	state_t     state_q, state_d;
	logic [4:0] div_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) begin
				div_cnt_q <= div_cnt_q + 5'd1;
			end else begin
				div_cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
				if (s_tvalid && st.is_tick) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = (st.mode == MODE_ZERO) ? S_DONE : S_READ;
			end
			S_READ: begin
				cmd.read = 1'b1;
				if (st.last_read) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				cmd.drain = 1'b1;
				state_d   = st.direct ? S_DONE : S_ROUND;
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (div_cnt_q == 5'(DIV_STEPS - 1)) begin
					state_d = S_SAT;
				end
			end
			S_SAT: begin
				cmd.sat = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!st.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

### sv/tsp_dp.sv
`default_nettype none
module tsp_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [1:0]        s_tuser,
	input  wire logic [79:0]       s_tdata,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [14:0]       cfg_wdata,
	input  wire tsp_pkg::cmd_t     cmd,
	output tsp_pkg::status_t       st,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [15:0]            m_tdata,
	output logic [0:0]             m_tuser
);
	import tsp_pkg::*;

	// floor(v / 1000) for non-negative v
	function automatic logic [4:0] div1000(input logic [14:0] v);
		logic [4:0] q;
		q = '0;
		for (int k = 1; k <= 16; k++) begin
			if (v >= 15'(k * 1000)) begin
				q = 5'(k);
			end
		end
		return q;
	endfunction

	logic [3:0]  bank_count_q;
	logic [14:0] step_span_q;
	logic [13:0] gate_thr_q;
	logic [14:0] blen_q [BANKS];

	logic signed [14:0] gate_q, pitch_q;
	logic signed [15:0] tune_q;

	logic [26:0] pos_q;
	logic        active_q, was_q;

	logic [2:0]  bank_q;
	logic [14:0] len_q, den_q, tden_q, idx_q;
	logic [11:0] rem_q, trem_q;
	logic [3:0]  k_q, left_q;
	logic        direct_q;

	logic        rd_v_s1, zero_s1;
	logic [13:0] w_s1;

	logic signed [31:0] acc_q;
	logic        neg_q;
	logic [19:0] dq_q;
	logic [3:0]  r_q;
	logic [15:0] audio_q;

	logic        out_valid_q, out_play_q;
	logic [15:0] out_audio_q;

	logic [15:0] rdata;

	// eval-cycle logic
	logic        high, rise, act;
	logic [26:0] pos_c;
	logic [27:0] p_c;
	logic [4:0]  q_c, b_c;
	logic [2:0]  sel_c;
	logic [14:0] len_c;
	logic        end_c, direct_c;
	logic [15:0] tden_c, den_c;
	mode_t       mode_c;
	logic signed [15:0] tc;

	always_comb begin
		high  = $signed(gate_q) >= $signed({1'b0, gate_thr_q});
		rise  = high && !was_q;
		act   = rise || active_q;
		pos_c = rise ? '0 : pos_q;
		p_c   = {1'b0, pos_c} + {13'b0, step_span_q};
		q_c   = div1000(pitch_q);
		b_c   = q_c - 5'd1;
		if (pitch_q[14] || q_c == 5'd0 || q_c >= {1'b0, bank_count_q} ||
		    b_c >= 5'(BANKS)) begin
			sel_c = '0;
		end else begin
			sel_c = b_c[2:0];
		end
		len_c    = blen_q[sel_c];
		end_c    = p_c >= {1'b0, len_c, 12'b0};
		den_c    = {1'b0, pos_c[26:12]};
		tden_c   = p_c[27:12];
		direct_c = (den_c == tden_c) && (den_c + 16'd1 >= {1'b0, len_c});
		if (!act || end_c) begin
			mode_c = MODE_ZERO;
		end else if (direct_c) begin
			mode_c = MODE_DIRECT;
		end else begin
			mode_c = MODE_MIX;
		end
		if (tune_q < TUNE_MIN) begin
			tc = TUNE_MIN;
		end else if (tune_q > TUNE_MAX) begin
			tc = TUNE_MAX;
		end else begin
			tc = tune_q;
		end
	end

	// weight of sample idx in the sum of both interpolations and the middle
	logic [15:0] i_c, d0, t0;
	logic [13:0] w_c;
	always_comb begin
		i_c = {1'b0, idx_q};
		d0  = {1'b0, den_q};
		t0  = {1'b0, tden_q};
		w_c = '0;
		if (i_c == d0) w_c = w_c + (14'd4096 - {2'b0, rem_q});
		if (i_c == d0 + 16'd1) w_c = w_c + {2'b0, rem_q};
		if (i_c > d0 && i_c < t0) w_c = w_c + 14'd4096;
		if (i_c == t0) w_c = w_c + (14'd4096 - {2'b0, trem_q});
		if (i_c == t0 + 16'd1) w_c = w_c + {2'b0, trem_q};
	end

	logic signed [30:0] prod;
	assign prod = $signed(rdata) * $signed({1'b0, w_s1});

	logic [31:0] mag_c, rnd_c;
	logic [4:0]  t_c;
	logic        ge_c;
	always_comb begin
		mag_c = acc_q[31] ? 32'(-acc_q) : 32'(acc_q);
		rnd_c = mag_c + {17'b0, k_q, 11'b0};
		t_c   = {r_q, dq_q[19]};
		ge_c  = t_c >= {1'b0, k_q};
	end

	logic signed [15:0] lv;
	logic [14:0]        len_sat;
	logic               ram_we;
	assign lv      = s_tdata[78:63];
	assign len_sat = lv[15] ? 15'd0 : (lv > 16'sd16384 ? 15'd16384 : lv[14:0]);
	assign ram_we  = cmd.capture && s_tuser == REQ_SAMPLE;

	tsp_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(STORE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr ({s_tdata[48:46], s_tdata[62:49]}),
		.wdata (s_tdata[78:63]),
		.raddr ({bank_q, idx_q[13:0]}),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_count_q <= 4'd0;
			step_span_q  <= 15'd4096;
			gate_thr_q   <= 14'd1700;
			for (int b = 0; b < BANKS; b++) begin
				blen_q[b] <= '0;
			end
			pos_q       <= '0;
			active_q    <= 1'b0;
			was_q       <= 1'b0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BANK_COUNT: bank_count_q <= cfg_wdata[3:0];
					CFG_STEP_SPAN:  step_span_q  <= cfg_wdata;
					CFG_GATE_THR:   gate_thr_q   <= cfg_wdata[13:0];
					default: ;
				endcase
			end
			if (cmd.capture && s_tuser == REQ_LEN) begin
				blen_q[s_tdata[48:46]] <= len_sat;
			end
			if (cmd.eval) begin
				was_q    <= high;
				active_q <= mode_c == MODE_MIX;
				if (act) begin
					pos_q <= pos_c + {14'b0, tc[12:0]};
				end
			end
			rd_v_s1 <= cmd.read;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			gate_q  <= s_tdata[14:0];
			pitch_q <= s_tdata[29:15];
			tune_q  <= s_tdata[45:30];
		end
		if (cmd.eval) begin
			bank_q   <= sel_c;
			len_q    <= len_c;
			den_q    <= den_c[14:0];
			rem_q    <= pos_c[11:0];
			tden_q   <= tden_c[14:0];
			trem_q   <= p_c[11:0];
			idx_q    <= den_c[14:0];
			direct_q <= mode_c == MODE_DIRECT;
			left_q   <= direct_c ? 4'd1 : 4'(tden_c - den_c + 16'd2);
			k_q      <= (tden_c > den_c) ? 4'(tden_c - den_c + 16'd1) : 4'd2;
			acc_q    <= '0;
			audio_q  <= '0;
		end
		if (cmd.read) begin
			idx_q   <= idx_q + 15'd1;
			left_q  <= left_q - 4'd1;
			w_s1    <= w_c;
			zero_s1 <= idx_q >= len_q;
		end
		if (rd_v_s1 && !zero_s1) begin
			acc_q <= acc_q + 32'(prod);
		end
		if (cmd.drain && direct_q) begin
			audio_q <= zero_s1 ? 16'd0 : rdata;
		end
		if (cmd.round) begin
			dq_q  <= rnd_c[31:12];
			r_q   <= '0;
			neg_q <= acc_q[31];
		end
		if (cmd.div) begin
			r_q  <= ge_c ? 4'(t_c - {1'b0, k_q}) : t_c[3:0];
			dq_q <= {dq_q[18:0], ge_c};
		end
		if (cmd.sat) begin
			if (neg_q) begin
				audio_q <= (dq_q > 20'd32768) ? 16'h8000 : 16'(~dq_q + 20'd1);
			end else begin
				audio_q <= (dq_q > 20'd32767) ? 16'h7fff : dq_q[15:0];
			end
		end
		if (cmd.emit) begin
			out_audio_q <= audio_q;
			out_play_q  <= active_q;
		end
	end

	always_comb begin
		st.is_tick   = s_tuser == REQ_TICK;
		st.mode      = mode_c;
		st.direct    = direct_q;
		st.last_read = left_q == 4'd1;
		st.out_busy  = out_valid_q && !m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_audio_q;
	assign m_tuser  = out_play_q;
endmodule
`default_nettype wire

### sv/triggered_sample_player_top.sv
// Load beats (sample word, bank length) leave the input ready; the next beat is taken right after.
// A tick that is not playing, or that ends the bank, goes from eval straight to the output state;
// one that ends inside a single sample reads that word, drains it and passes it to the output.
// Otherwise it reads n = 2..10 words, rounds, runs a 20-step restoring divider and saturates;
// one tick in flight, and the input is ready again once the result is handed to the output.
// Reset (arst_n low, async) clears control, position, bank lengths and config; memory is not.
`default_nettype none
module triggered_sample_player_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// gate_mv[14:0], pitch_mv[29:15], tune_step[45:30], load_bank[48:46],
	// load_addr[62:49], load_value[78:63], zero[79]
	input  wire logic [79:0] s_tdata,
	// req_type[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// audio_out[15:0]
	output logic [15:0]      m_tdata,
	// is_playing[0]
	output logic [0:0]       m_tuser,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [14:0] cfg_wdata
);
	import tsp_pkg::*;

	cmd_t    cmd;
	status_t st;

	tsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	tsp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.st        (st),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);
endmodule
`default_nettype wire

### sv/tsp_checker.sv
`default_nettype none
module tsp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic [0:0]  m_tuser
);
	import tsp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result beat changed");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == REQ_TICK |=> !s_tready)
		else $error("new beat taken while a tick is in flight");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == REQ_SAMPLE || s_tuser == REQ_LEN) |=> s_tready)
		else $error("load beat stalled the input");
endmodule

bind triggered_sample_player_top tsp_checker u_chk (.*);
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import tsp_pkg::*;

	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE = 50;

	typedef struct {
		logic [1:0]         kind;
		logic signed [14:0] gate;
		logic signed [14:0] pitch;
		logic signed [15:0] tune;
		logic [2:0]         bank;
		logic [13:0]        addr;
		logic signed [15:0] value;
	} beat_t;

	typedef struct {
		logic signed [15:0] audio;
		logic               playing;
	} sound_t;

	// directed row: beat plus optional hand-written result
	typedef struct {
		beat_t  b;
		bit     typed;
		sound_t res;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [14:0] cfg_wdata;

	triggered_sample_player_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// player shadow
	shortint      samples [STORE_DEPTH];
	bit           written [STORE_DEPTH];
	int           filled_to [BANKS];
	int           bank_len [BANKS];
	longint       position;
	bit           active;
	bit           gate_prev;
	int           n_banks;
	int           span_q12;
	int           gate_thr;

	sound_t       pending [$];
	int           errors;
	bit           quiet;
	int           rx_hold;
	longint       cycles;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver ready, with optional long hold-off
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet || ($urandom_range(99) >= 8);
		end
	end

	always @(posedge clk) begin
		sound_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat audio=%0d playing=%0d", $time,
					$signed(m_tdata), m_tuser[0]);
			end else begin
				want = pending.pop_front();
				if ($signed(m_tdata) !== want.audio) begin
					errors++;
					$display("%0t: audio_out expected %0d got %0d", $time, want.audio,
						$signed(m_tdata));
				end
				if (m_tuser[0] !== want.playing) begin
					errors++;
					$display("%0t: is_playing expected %0d got %0d", $time, want.playing,
						m_tuser[0]);
				end
			end
		end
	end

	function automatic longint word_at(int bank, longint idx);
		if (idx >= bank_len[bank] || idx >= BANK_DEPTH)
			return 0;
		return samples[bank * BANK_DEPTH + idx];
	endfunction

	function automatic longint lerp(int bank, longint whole, longint frac);
		return ((longint'(1) << FRAC_BITS) - frac) * word_at(bank, whole)
			+ frac * word_at(bank, whole + 1);
	endfunction

	// returns 1 when the beat yields a result
	function automatic bit player_step(beat_t b, output sound_t r);
		longint gate, pitch, tune, p, lenq, den, rem, tden, trem, total, dv, mag, aud;
		int bank, cnt;
		bit high;
		r.audio = '0;
		r.playing = 1'b0;
		if (b.kind == REQ_SAMPLE) begin
			samples[b.bank * BANK_DEPTH + b.addr] = b.value;
			written[b.bank * BANK_DEPTH + b.addr] = 1'b1;
			while (filled_to[b.bank] < BANK_DEPTH
					&& written[b.bank * BANK_DEPTH + filled_to[b.bank]])
				filled_to[b.bank]++;
			return 1'b0;
		end
		if (b.kind == REQ_LEN) begin
			bank_len[b.bank] = (b.value < 0) ? 0 : int'(b.value);
			if (bank_len[b.bank] > BANK_DEPTH)
				bank_len[b.bank] = BANK_DEPTH;
			return 1'b0;
		end
		if (b.kind != REQ_TICK)
			return 1'b0;
		gate = b.gate;
		pitch = b.pitch;
		tune = b.tune;
		high = gate >= gate_thr;
		aud = 0;
		if (high && !gate_prev) begin
			position = 0;
			active = 1'b1;
		end
		gate_prev = high;
		if (active) begin
			bank = 0;
			p = position + span_q12;
			if (!(pitch < 1000 || pitch >= 1000 * n_banks)) begin
				if (pitch / 1000 - 1 >= 0 && pitch / 1000 - 1 < BANKS)
					bank = int'(pitch / 1000 - 1);
			end
			lenq = longint'(bank_len[bank]) << FRAC_BITS;
			if (p >= lenq) begin
				active = 1'b0;
			end else begin
				den = position >> FRAC_BITS;
				rem = position & ((1 << FRAC_BITS) - 1);
				tden = p >> FRAC_BITS;
				trem = p & ((1 << FRAC_BITS) - 1);
				if (den == tden && den + 1 >= bank_len[bank]) begin
					active = 1'b0;
					aud = word_at(bank, den);
				end else begin
					total = lerp(bank, den, rem) + lerp(bank, tden, trem);
					cnt = 0;
					for (longint i = den + 1; i < tden; i++) begin
						total += word_at(bank, i) << FRAC_BITS;
						cnt++;
					end
					dv = longint'(2 + cnt) << FRAC_BITS;
					mag = (total < 0) ? -total : total;
					mag = (mag + dv / 2) / dv;
					aud = (total < 0) ? -mag : mag;
					if (aud > 32767) aud = 32767;
					if (aud < -32768) aud = -32768;
				end
			end
			if (tune < TUNE_MIN) tune = TUNE_MIN;
			if (tune > TUNE_MAX) tune = TUNE_MAX;
			position += tune;
		end
		r.audio = aud[15:0];
		r.playing = active;
		return 1'b1;
	endfunction

	task automatic send(beat_t b, bit typed = 0, sound_t fixed = '{0, 0});
		sound_t r;
		while (!quiet && $urandom_range(99) < 8) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= b.kind;
		s_tdata <= {1'b0, b.value, b.addr, b.bank, b.tune, b.pitch, b.gate};
		do @(posedge clk); while (!s_tready);
		if (player_step(b, r))
			pending.push_back(typed ? fixed : r);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[14:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == CFG_BANK_COUNT) n_banks = val;
		else if (idx == CFG_STEP_SPAN) span_q12 = val;
		else gate_thr = val;
	endtask

	function automatic beat_t load(logic [1:0] k, int bank, int addr, int val);
		beat_t b;
		b = '{k, 15'($urandom), 15'($urandom), 16'($urandom), bank[2:0], addr[13:0],
			val[15:0]};
		return b;
	endfunction

	function automatic beat_t tick(int g, int p, int t);
		beat_t b;
		b = '{REQ_TICK, g[14:0], p[14:0], t[15:0], 3'($urandom), 14'($urandom),
			16'($urandom)};
		return b;
	endfunction

	function automatic int gate_hi();
		return $urandom_range(16383, gate_thr);
	endfunction

	function automatic int gate_lo();
		int g;
		g = gate_thr - int'($urandom_range(16384, 1));
		return (g < -16384) ? -16384 : g;
	endfunction

	function automatic int any_tune();
		if ($urandom_range(9) == 0)
			return $signed(16'($urandom));
		return $urandom_range(9000, 0);
	endfunction

	function automatic int any_pitch();
		if ($urandom_range(7) == 0)
			return $signed(16'($urandom));
		return $urandom_range(9999, 0);
	endfunction

	// length that only covers words already written
	function automatic int safe_len(int bank);
		if (filled_to[bank] == BANK_DEPTH && $urandom_range(9) == 0)
			return $signed(16'($urandom));
		return $urandom_range((filled_to[bank] < 80) ? filled_to[bank] : 80, 0);
	endfunction

	task automatic random_burst(int n);
		int k, nt, bk;
		k = 0;
		while (k < n) begin
			case ($urandom_range(9))
				0: begin
					send(load(REQ_SAMPLE, $urandom, ($urandom_range(3) == 0) ? $urandom
						: $urandom_range(90, 0), $urandom));
					k++;
				end
				1: begin
					bk = $urandom_range(BANKS - 1);
					send(load(REQ_LEN, bk, $urandom, safe_len(bk)));
					k++;
				end
				2: begin
					send(load(REQ_NONE, $urandom, $urandom, $urandom));
				end
				3: begin
					send(tick($signed(15'($urandom)), any_pitch(), any_tune()));
					k++;
				end
				default: begin
					// trigger and play a stretch of the bank
					send(tick(gate_lo(), any_pitch(), any_tune()));
					nt = $urandom_range(60, 3);
					bk = any_pitch();
					for (int i = 0; i < nt && k < n; i++) begin
						if ($urandom_range(5) == 0) bk = any_pitch();
						send(tick(($urandom_range(19) == 0) ? gate_lo() : gate_hi(), bk,
							any_tune()));
						k++;
					end
					k++;
				end
			endcase
		end
	endtask

	row_t rows [$];
	int   settings [6][3];

	initial begin
		errors = 0;
		quiet = 1'b0;
		rx_hold = 0;
		cycles = 0;
		position = 0;
		active = 0;
		gate_prev = 0;
		n_banks = 0;
		span_q12 = 4096;
		gate_thr = 1700;
		foreach (bank_len[i]) bank_len[i] = 0;
		foreach (filled_to[i]) filled_to[i] = 0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_TICK;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_BANK_COUNT;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// straight after reset: nothing loaded, nothing plays
		rows.push_back('{tick(0, 0, 0), 1, '{0, 0}});
		rows.push_back('{tick(12000, 5000, 4096), 1, '{0, 0}});
		rows.push_back('{tick(-12000, -12000, -32768), 1, '{0, 0}});
		foreach (rows[i]) send(rows[i].b, rows[i].typed, rows[i].res);
		rows.delete();

		// setup: a short prefix of every bank
		quiet = 1'b1;
		for (int bk = 0; bk < BANKS; bk++)
			for (int a = 0; a < 64; a++)
				send(load(REQ_SAMPLE, bk, a, $urandom));
		quiet = 1'b0;

		write_reg(CFG_BANK_COUNT, 8);
		rows.push_back('{load(REQ_SAMPLE, 7, 16383, 32767), 0, '{0, 0}});
		rows.push_back('{load(REQ_SAMPLE, 0, 0, -32768), 0, '{0, 0}});
		rows.push_back('{load(REQ_SAMPLE, 0, 1, 32767), 0, '{0, 0}});
		rows.push_back('{load(REQ_LEN, 7, 0, 32767), 0, '{0, 0}});
		rows.push_back('{load(REQ_LEN, 0, 0, -32768), 0, '{0, 0}});
		rows.push_back('{load(REQ_NONE, 7, 16383, -1), 0, '{0, 0}});
		// bank 0 empty: rising gate stops at once
		rows.push_back('{tick(1700, 999, 4096), 1, '{0, 0}});
		rows.push_back('{load(REQ_LEN, 0, 0, 2), 0, '{0, 0}});
		rows.push_back('{tick(0, 0, 0), 1, '{0, 0}});
		// play bank 0 from its first sample to the end of the bank
		rows.push_back('{tick(1700, 500, -32768), 0, '{0, 0}});
		rows.push_back('{tick(12000, 500, 32767), 0, '{0, 0}});
		rows.push_back('{tick(16383, 500, 4096), 0, '{0, 0}});
		// pitch extremes
		rows.push_back('{tick(0, 0, 0), 0, '{0, 0}});
		rows.push_back('{tick(12000, 8000, 819), 0, '{0, 0}});
		rows.push_back('{tick(12000, 8999, 7373), 0, '{0, 0}});
		rows.push_back('{tick(12000, 9000, 818), 0, '{0, 0}});
		rows.push_back('{tick(12000, -16384, 7374), 0, '{0, 0}});
		rows.push_back('{tick(1699, 16383, 0), 0, '{0, 0}});
		// bank 7 back to its written prefix
		rows.push_back('{load(REQ_LEN, 7, 0, 64), 0, '{0, 0}});
		foreach (rows[i]) send(rows[i].b, rows[i].typed, rows[i].res);

		settings = '{'{8, 4096, 1700}, '{0, 0, 0}, '{8, 16384, 12000},
			'{3, 1, 500}, '{5, 10000, 0}, '{8, 2048, 3000}};
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_BANK_COUNT, settings[ph][0]);
			write_reg(CFG_STEP_SPAN, settings[ph][1]);
			write_reg(CFG_GATE_THR, settings[ph][2]);
			quiet = (ph == 2);
			if (ph == 3)
				rx_hold = 400;
			random_burst(200);
			if (ph == 4)
				drain();
		end

		drain();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire

### filelist.f
sv/tsp_pkg.sv
sv/tsp_ram.sv
sv/tsp_ctrl.sv
sv/tsp_dp.sv
sv/triggered_sample_player_top.sv
sv/tsp_checker.sv
dv/tb_top.sv
